// ----- sv/bgph_pkg.sv -----
// Shared constants and register codes for the bar graph with peak hold.
package bgph_pkg;

  localparam int LEVEL_W    = 8;   // input level width
  localparam int CFG_W      = 8;   // configuration data width
  localparam int CFG_ADDR_W = 1;   // configuration register index width
  localparam int CODE_W     = 8;   // character code width
  localparam int COL_W      = 4;   // column field width on the output
  localparam int M_DATA_W   = 16;  // output tdata width, byte aligned

  localparam logic [CODE_W-1:0] CHAR_BLOCK = 8'hFF;
  localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [CFG_W-1:0] FULL_SCALE_RST = 8'd255;
  localparam logic [CFG_W-1:0] HOLD_TICKS_RST = 8'd40;

  localparam logic [CFG_ADDR_W-1:0] REG_FULL_SCALE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS = 1'd1;

endpackage

// ----- sv/bgph_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module bgph_div #(
  parameter int NUM_W = 13,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign quo   = num_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(NUM_W);
        num_sh <= num;
        den_r  <= den;
        rem    <= '0;
      end else if (busy) begin
        // shift in the next numerator bit, subtract when it fits
        rem    <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_sh <= {num_sh[NUM_W-2:0], ge};
        cnt    <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/bgph_row.sv -----
// Peak hold state and column serializer with output register.
module bgph_row #(
  parameter int COLUMNS = 16,
  parameter int QUO_W   = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bgph_pkg::CFG_W-1:0]    hold_ticks,
  input  logic                          quo_valid,
  input  logic [QUO_W-1:0]              quo,
  output logic                          busy,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bgph_pkg::CODE_W-1:0]   char_code,
  output logic [bgph_pkg::COL_W-1:0]    column,
  output logic                          m_tlast
);

  localparam int LEN_W = $clog2(COLUMNS + 1);
  localparam int CW    = $clog2(COLUMNS);

  typedef enum logic {IDLE, EMIT} state_t;

  state_t                     state;
  logic [LEN_W-1:0]           peak;
  logic [bgph_pkg::CFG_W-1:0] hold_count;
  logic [LEN_W-1:0]           len_r;
  logic [CW-1:0]              col;

  logic [LEN_W-1:0]           len;
  logic                       reload;
  logic [LEN_W-1:0]           col_ext;
  logic [bgph_pkg::CODE_W-1:0] ch;

  // saturate the rounded quotient into a bar length
  assign len    = (quo >= QUO_W'(COLUMNS - 1)) ? LEN_W'(COLUMNS)
                                               : LEN_W'(quo) + LEN_W'(1);
  assign reload = (hold_count == '0) || (len >= peak);
  assign col_ext = LEN_W'(col);

  always_comb begin
    ch = bgph_pkg::CHAR_SPACE;
    if (col_ext < len_r) begin
      ch = bgph_pkg::CHAR_BLOCK;
    end else if ((len_r < peak) && (col_ext + LEN_W'(1) == peak)) begin
      ch = bgph_pkg::CHAR_BLOCK;
    end
  end

  assign busy = (state != IDLE) || m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      peak       <= '0;
      hold_count <= '0;
      col        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (quo_valid) begin
            len_r <= len;
            col   <= '0;
            state <= EMIT;
            if (reload) begin
              peak       <= len;
              hold_count <= hold_ticks;
            end else begin
              hold_count <= hold_count - 8'd1;
            end
          end
        end
        EMIT: begin
          // load the next beat once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            char_code <= ch;
            column    <= bgph_pkg::COL_W'(col);
            m_tlast   <= (col == CW'(COLUMNS - 1));
            col       <= col + CW'(1);
            if (col == CW'(COLUMNS - 1)) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- sv/bar_graph_peak_hold.sv -----
// Top level of the bar graph with peak hold.
// Usage:
//   Slave stream: one beat per refresh tick, s_tdata = level.
//   Master stream: COLUMNS beats per tick, left column first,
//   m_tdata = char_code (0xFF block, 0x20 space) and column, m_tlast on the
//   rightmost column.
//   Config port: cfg_we writes cfg_data into register cfg_addr
//   (0 full_scale, 1 hold_ticks); write only while the block is idle.
// Timing:
//   The level is scaled and divided by a bit-serial divider, one quotient
//   bit per cycle. Its done pulse moves the row serializer to EMIT, which
//   then loads the first column beat into the output register; further
//   beats follow one per cycle while m_tready is high. s_tready is low
//   from acceptance until the last beat is taken.
// Reset:
//   rst clears peak and hold counter, loads full_scale 255, hold_ticks 40,
//   and drops m_tvalid.
// Stall:
//   A low m_tready holds the current beat in the output register and
//   pauses the column sequence.
module bar_graph_peak_hold #(
  parameter int COLUMNS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bgph_pkg::LEVEL_W-1:0]      s_tdata,  // [7:0] level
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bgph_pkg::M_DATA_W-1:0]     m_tdata,  // [7:0] char_code, [11:8] column
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [bgph_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bgph_pkg::CFG_W-1:0]        cfg_data
);

  localparam int NUM_MAX = 2 * (COLUMNS - 1) * 255 + 255;
  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int DEN_W   = bgph_pkg::CFG_W + 1;

  logic [bgph_pkg::CFG_W-1:0]  full_scale;
  logic [bgph_pkg::CFG_W-1:0]  hold_ticks;
  logic [bgph_pkg::CFG_W-1:0]  fs_eff;
  logic [NUM_W-1:0]            num;
  logic [DEN_W-1:0]            den;
  logic                        start;
  logic                        div_busy;
  logic                        div_done;
  logic [NUM_W-1:0]            quo;
  logic                        row_busy;
  logic [bgph_pkg::CODE_W-1:0] char_code;
  logic [bgph_pkg::COL_W-1:0]  column;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= bgph_pkg::FULL_SCALE_RST;
      hold_ticks <= bgph_pkg::HOLD_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bgph_pkg::REG_FULL_SCALE: full_scale <= cfg_data;
        bgph_pkg::REG_HOLD_TICKS: hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero full scale counts as one
  assign fs_eff = (full_scale == '0) ? bgph_pkg::CFG_W'(1) : full_scale;
  assign num    = NUM_W'(2 * (COLUMNS - 1)) * NUM_W'(s_tdata) + NUM_W'(fs_eff);
  assign den    = {fs_eff, 1'b0};

  assign s_tready = !div_busy && !div_done && !row_busy;
  assign start    = s_tvalid && s_tready;

  bgph_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  bgph_row #(
    .COLUMNS (COLUMNS),
    .QUO_W   (NUM_W)
  ) u_row (
    .clk        (clk),
    .rst        (rst),
    .hold_ticks (hold_ticks),
    .quo_valid  (div_done),
    .quo        (quo),
    .busy       (row_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .char_code  (char_code),
    .column     (column),
    .m_tlast    (m_tlast)
  );

  assign m_tdata = {4'd0, column, char_code};

endmodule
